>>> rtl/core/pdt_pkg.sv
`timescale 1ns / 1ps

package pdt_pkg;

    // Field widths of the measurement and result words.
    localparam int PAD_W   = 3;
    localparam int SIDE_W  = 12;
    localparam int LIT_W   = 24;
    localparam int TIME_W  = 32;
    localparam int RUN_W   = 4;

    // Configuration register widths.
    localparam int THR_W   = 6;
    localparam int CNT_W   = 4;
    localparam int COOL_W  = 16;
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 4;

    // Shared multiplier operand and product widths.
    localparam int MUL_A_W = 24;
    localparam int MUL_B_W = 12;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Threshold side product (threshold * width * height) fits in 30 bits,
    // the lit side (lit * 100) in 31 bits.
    localparam int RHS_W   = 30;
    localparam int LHS_W   = 31;

    localparam int DEF_PAD_COUNT = 5;

    localparam logic [SIDE_W-1:0]  MIN_SIDE  = 12'd5;
    localparam logic [RUN_W-1:0]   RUN_MAX   = 4'd15;
    localparam logic [MUL_B_W-1:0] LIT_SCALE = 12'd100;

    localparam logic [THR_W-1:0]  THR_RESET   = 6'd3;
    localparam logic [CNT_W-1:0]  ENTER_RESET = 4'd2;
    localparam logic [CNT_W-1:0]  EXIT_RESET  = 4'd3;
    localparam logic [COOL_W-1:0] COOL_RESET  = 16'd120;

    // Register indexes (byte address = 4 * index).
    typedef enum logic [1:0] {
        REG_THRESHOLD = 2'd0,
        REG_ENTER     = 2'd1,
        REG_EXIT      = 2'd2,
        REG_COOLDOWN  = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_WH,
        ST_MUL_THR,
        ST_MUL_LIT,
        ST_CMP,
        ST_FINAL
    } state_t;

    // Request to the shared multiplier.
    typedef struct packed {
        logic               en;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mul_req_t;

endpackage

>>> rtl/core/pdt_in_if.sv
`timescale 1ns / 1ps

interface pdt_in_if;
    logic                          valid;
    logic                          ready;
    logic [pdt_pkg::PAD_W-1:0]     pad_index;
    logic [pdt_pkg::SIDE_W-1:0]    region_width;
    logic [pdt_pkg::SIDE_W-1:0]    region_height;
    logic [pdt_pkg::LIT_W-1:0]     lit_pixels;
    logic [pdt_pkg::TIME_W-1:0]    now_ms;

    modport source (
        output valid, pad_index, region_width, region_height, lit_pixels, now_ms,
        input  ready
    );

    modport sink (
        input  valid, pad_index, region_width, region_height, lit_pixels, now_ms,
        output ready
    );
endinterface

>>> rtl/core/pdt_out_if.sv
`timescale 1ns / 1ps

interface pdt_out_if;
    logic                      valid;
    logic                      ready;
    logic [pdt_pkg::PAD_W-1:0] pad_out;
    logic                      skipped;
    logic                      hit_now;
    logic                      pad_active;
    logic                      fire;

    modport source (
        output valid, pad_out, skipped, hit_now, pad_active, fire,
        input  ready
    );

    modport sink (
        input  valid, pad_out, skipped, hit_now, pad_active, fire,
        output ready
    );
endinterface

>>> rtl/core/pad_hit_debounce_trigger_top.sv
`timescale 1ns / 1ps

// Channel    | Dir | Handshake              | Word
// -----------+-----+------------------------+-----------------------------------------
// in_ch      | in  | valid/ready            | pad_index, region_width, region_height,
//            |     |                        | lit_pixels, now_ms
// out_ch     | out | valid/ready            | pad_out, skipped, hit_now, pad_active, fire
// APB        | in  | psel/penable, pready=1 | 4 registers at byte addresses 0, 4, 8, 12
//
// A measured word goes through these steps before the next acceptance: three
// passes through the single shared multiplier (width*height, times the
// threshold, lit*100), a compare cycle and a final update cycle, then ready.
// A skipped word (small region or out-of-range pad) skips to the final update.
// Reset (rst_n, asynchronous, active low) clears all pad state and loads
// the register defaults. A stalled output only holds the final update
// cycle; the result register frees as soon as the sink takes the word.
module pad_hit_debounce_trigger_top #(
    parameter int PAD_COUNT = pdt_pkg::DEF_PAD_COUNT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pdt_pkg::APB_AW-1:0]   paddr,
    input  logic [pdt_pkg::APB_DW-1:0]   pwdata,
    output logic [pdt_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    pdt_in_if.sink                       in_ch,
    pdt_out_if.source                    out_ch
);

    // Index width of the per-pad state arrays.
    localparam int IDX_W = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;
    localparam logic [4:0] PAD_LIMIT = 5'(PAD_COUNT);

    // ------------------------------------------------------------------
    // Configuration registers. Writes complete in the APB access cycle.
    // ------------------------------------------------------------------
    logic [pdt_pkg::THR_W-1:0]  thr_reg;
    logic [pdt_pkg::CNT_W-1:0]  enter_reg;
    logic [pdt_pkg::CNT_W-1:0]  exit_reg;
    logic [pdt_pkg::COOL_W-1:0] cool_reg;
    logic                       cfg_wr;
    pdt_pkg::reg_idx_t          cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = pdt_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= pdt_pkg::THR_RESET;
            enter_reg <= pdt_pkg::ENTER_RESET;
            exit_reg  <= pdt_pkg::EXIT_RESET;
            cool_reg  <= pdt_pkg::COOL_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                pdt_pkg::REG_THRESHOLD: thr_reg   <= pwdata[pdt_pkg::THR_W-1:0];
                pdt_pkg::REG_ENTER:     enter_reg <= pwdata[pdt_pkg::CNT_W-1:0];
                pdt_pkg::REG_EXIT:      exit_reg  <= pwdata[pdt_pkg::CNT_W-1:0];
                pdt_pkg::REG_COOLDOWN:  cool_reg  <= pwdata[pdt_pkg::COOL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            pdt_pkg::REG_THRESHOLD: prdata = pdt_pkg::APB_DW'(thr_reg);
            pdt_pkg::REG_ENTER:     prdata = pdt_pkg::APB_DW'(enter_reg);
            pdt_pkg::REG_EXIT:      prdata = pdt_pkg::APB_DW'(exit_reg);
            pdt_pkg::REG_COOLDOWN:  prdata = pdt_pkg::APB_DW'(cool_reg);
            default:                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    pdt_pkg::state_t state_reg;
    pdt_pkg::state_t state_next;

    logic in_acc;
    logic commit;
    logic out_free;
    logic in_small;
    logic in_oor;

    // Captured input word.
    logic [pdt_pkg::PAD_W-1:0]  pad_reg;
    logic [pdt_pkg::SIDE_W-1:0] w_reg;
    logic [pdt_pkg::SIDE_W-1:0] h_reg;
    logic [pdt_pkg::LIT_W-1:0]  lit_reg;
    logic [pdt_pkg::TIME_W-1:0] now_reg;
    logic                       skip_reg;
    logic                       oor_reg;

    // Intermediate results.
    logic [pdt_pkg::RHS_W-1:0]  rhs_reg;
    logic                       hit_reg;
    logic [pdt_pkg::PROD_W-1:0] prod;
    pdt_pkg::mul_req_t          mul_req;

    assign in_oor   = ({2'b00, in_ch.pad_index} >= PAD_LIMIT);
    assign in_small = (in_ch.region_width < pdt_pkg::MIN_SIDE) ||
                      (in_ch.region_height < pdt_pkg::MIN_SIDE);
    assign in_acc   = in_ch.valid && in_ch.ready;
    assign out_free = !out_ch.valid || out_ch.ready;
    assign commit   = (state_reg == pdt_pkg::ST_FINAL) && out_free;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pdt_pkg::ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    state_next = (in_oor || in_small) ? pdt_pkg::ST_FINAL
                                                      : pdt_pkg::ST_MUL_WH;
                end
            end
            pdt_pkg::ST_MUL_WH:  state_next = pdt_pkg::ST_MUL_THR;
            pdt_pkg::ST_MUL_THR: state_next = pdt_pkg::ST_MUL_LIT;
            pdt_pkg::ST_MUL_LIT: state_next = pdt_pkg::ST_CMP;
            pdt_pkg::ST_CMP:     state_next = pdt_pkg::ST_FINAL;
            pdt_pkg::ST_FINAL:
            begin
                if (out_free)
                begin
                    state_next = pdt_pkg::ST_IDLE;
                end
            end
            default:             state_next = pdt_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs: input ready and the multiplier operands.
    always_comb
    begin
        in_ch.ready = 1'b0;
        mul_req     = '0;
        unique case (state_reg)
            pdt_pkg::ST_IDLE:
            begin
                in_ch.ready = 1'b1;
            end
            pdt_pkg::ST_MUL_WH:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = pdt_pkg::MUL_A_W'(w_reg);
                mul_req.b  = h_reg;
            end
            pdt_pkg::ST_MUL_THR:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = prod[pdt_pkg::MUL_A_W-1:0];
                mul_req.b  = pdt_pkg::MUL_B_W'(thr_reg);
            end
            pdt_pkg::ST_MUL_LIT:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = lit_reg;
                mul_req.b  = pdt_pkg::LIT_SCALE;
            end
            pdt_pkg::ST_CMP:   ;
            pdt_pkg::ST_FINAL: ;
            default:           ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pdt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    pdt_mul_unit u_mul (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

    // Input capture and intermediate registers hold payload only.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            pad_reg  <= in_ch.pad_index;
            w_reg    <= in_ch.region_width;
            h_reg    <= in_ch.region_height;
            lit_reg  <= in_ch.lit_pixels;
            now_reg  <= in_ch.now_ms;
            skip_reg <= in_oor || in_small;
            oor_reg  <= in_oor;
        end
        // The threshold product is ready while the lit product is formed.
        if (state_reg == pdt_pkg::ST_MUL_LIT)
        begin
            rhs_reg <= prod[pdt_pkg::RHS_W-1:0];
        end
        if (state_reg == pdt_pkg::ST_CMP)
        begin
            hit_reg <= (prod[pdt_pkg::LHS_W-1:0] >= pdt_pkg::LHS_W'(rhs_reg));
        end
    end

    // ------------------------------------------------------------------
    // Per-pad state and the final update.
    // ------------------------------------------------------------------
    logic [pdt_pkg::RUN_W-1:0]  hit_run_reg  [PAD_COUNT];
    logic [pdt_pkg::RUN_W-1:0]  miss_run_reg [PAD_COUNT];
    logic                       active_reg   [PAD_COUNT];
    logic [pdt_pkg::TIME_W-1:0] fire_time_reg[PAD_COUNT];
    logic                       fired_reg    [PAD_COUNT];

    logic [4:0]                 pad_wide;
    logic [IDX_W-1:0]           idx;
    logic [pdt_pkg::RUN_W-1:0]  hr_cur;
    logic [pdt_pkg::RUN_W-1:0]  mr_cur;
    logic                       act_cur;
    logic [pdt_pkg::TIME_W-1:0] lft_cur;
    logic                       hf_cur;
    logic [pdt_pkg::TIME_W-1:0] elapsed;
    logic [pdt_pkg::RUN_W-1:0]  hr_next;
    logic [pdt_pkg::RUN_W-1:0]  mr_next;
    logic                       act_next;
    logic                       fire_next;

    // Out-of-range pads never touch the arrays; steer them to entry zero.
    assign pad_wide = {2'b00, pad_reg};
    assign idx      = oor_reg ? '0 : pad_wide[IDX_W-1:0];
    assign hr_cur   = hit_run_reg[idx];
    assign mr_cur   = miss_run_reg[idx];
    assign act_cur  = active_reg[idx];
    assign lft_cur  = fire_time_reg[idx];
    assign hf_cur   = fired_reg[idx];
    assign elapsed  = now_reg - lft_cur;

    always_comb
    begin
        hr_next   = hr_cur;
        mr_next   = mr_cur;
        act_next  = act_cur;
        fire_next = 1'b0;
        if (hit_reg)
        begin
            hr_next = (hr_cur == pdt_pkg::RUN_MAX) ? hr_cur
                                                   : hr_cur + pdt_pkg::RUN_W'(1);
            mr_next = '0;
            if (!act_cur && (hr_next >= enter_reg))
            begin
                act_next = 1'b1;
                // A pad that has never fired is not held off by the cooldown.
                fire_next = !hf_cur ||
                            (elapsed >= pdt_pkg::TIME_W'(cool_reg));
            end
        end
        else
        begin
            mr_next = (mr_cur == pdt_pkg::RUN_MAX) ? mr_cur
                                                   : mr_cur + pdt_pkg::RUN_W'(1);
            hr_next = '0;
            if (act_cur && (mr_next >= exit_reg))
            begin
                act_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < PAD_COUNT; p++)
            begin
                hit_run_reg[p]   <= '0;
                miss_run_reg[p]  <= '0;
                active_reg[p]    <= 1'b0;
                fire_time_reg[p] <= '0;
                fired_reg[p]     <= 1'b0;
            end
        end
        else if (commit && !skip_reg)
        begin
            hit_run_reg[idx]  <= hr_next;
            miss_run_reg[idx] <= mr_next;
            active_reg[idx]   <= act_next;
            if (fire_next)
            begin
                fire_time_reg[idx] <= now_reg;
                fired_reg[idx]     <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register. It is loaded in the final cycle when the previous
    // word is gone or leaving in the same cycle.
    // ------------------------------------------------------------------
    logic                      out_valid_reg;
    logic [pdt_pkg::PAD_W-1:0] pad_out_reg;
    logic                      skipped_reg;
    logic                      hit_now_reg;
    logic                      active_out_reg;
    logic                      fire_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            pad_out_reg    <= pad_reg;
            skipped_reg    <= skip_reg;
            hit_now_reg    <= !skip_reg && hit_reg;
            fire_reg       <= !skip_reg && fire_next;
            if (oor_reg)
            begin
                active_out_reg <= 1'b0;
            end
            else if (skip_reg)
            begin
                active_out_reg <= act_cur;
            end
            else
            begin
                active_out_reg <= act_next;
            end
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.pad_out    = pad_out_reg;
    assign out_ch.skipped    = skipped_reg;
    assign out_ch.hit_now    = hit_now_reg;
    assign out_ch.pad_active = active_out_reg;
    assign out_ch.fire       = fire_reg;

`ifndef SYNTHESIS
    // A fire always comes with the pad becoming active on a measured frame.
    a_fire_active: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.fire) |->
        (out_ch.pad_active && out_ch.hit_now && !out_ch.skipped))
        else $error("fire without an active measured hit");

    // A skipped word reports neither a hit nor a fire.
    a_skip_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.skipped) |-> (!out_ch.hit_now && !out_ch.fire))
        else $error("skipped word carries a hit or a fire");

    // The sequencer takes no new word until the current one is committed.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_ch.ready)
        else $error("input accepted while a word is in progress");

    // After the compare cycle the final update always follows.
    a_cmp_to_final: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pdt_pkg::ST_CMP) |=> (state_reg == pdt_pkg::ST_FINAL))
        else $error("compare not followed by final update");

    // A committed word is visible on the output in the next cycle.
    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> out_ch.valid)
        else $error("committed word missing from the output");
`endif

endmodule

>>> rtl/core/pdt_mul_unit.sv
`timescale 1ns / 1ps

// Shared unsigned multiplier with a registered product. The sequencer
// feeds it one operand pair per cycle and reads the product in the next cycle.
module pdt_mul_unit (
    input  logic                          clk,
    input  pdt_pkg::mul_req_t             req,
    output logic [pdt_pkg::PROD_W-1:0]    prod
);

    logic [pdt_pkg::PROD_W-1:0] prod_reg;
    logic [pdt_pkg::PROD_W-1:0] prod_next;

    always_comb
    begin
        prod_next = pdt_pkg::PROD_W'(req.a) * pdt_pkg::PROD_W'(req.b);
    end

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule
